// ===== hw/rtl/ctd_pkg.sv =====
// Shared types and constants of the chunked transfer decoder.
package ctd_pkg;

  // Result kinds as they appear on the kind port.
  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_OK     = 3'd1,
    KIND_NOLINE = 3'd2,
    KIND_SHORT  = 3'd3,
    KIND_OVER   = 3'd4
  } kind_t;

  // Characters that the size line parser looks for.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  // One classified input byte: an optional data result followed by an
  // optional status result.
  typedef struct packed {
    logic       has_data;
    logic [7:0] data;
    logic       has_status;
    kind_t      status;
  } entry_t;

endpackage

// ===== hw/rtl/ctd_front.sv =====
// Front end: parses the chunked byte stream and classifies each byte.
module ctd_front #(
  parameter int SIZE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            final_byte,
  output logic            entry_valid,
  output ctd_pkg::entry_t entry
);
  import ctd_pkg::*;

  typedef enum logic [1:0] {
    PH_SIZE,
    PH_DATA,
    PH_TRAILER,
    PH_IGNORE
  } phase_t;

  phase_t               phase, phase_next;
  // Holds the chunk size while parsing and counts the remaining data bytes.
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic                 hex_done, hex_done_next;
  logic                 saw_cr, saw_cr_next;
  logic                 trailer_seen, trailer_seen_next;

  logic                 is_hex;
  logic [3:0]           digit;
  logic                 size_full;

  // Hex digit decode in either case.
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (in_byte >= CHAR_0 && in_byte <= CHAR_9) begin
      digit = 4'(in_byte - CHAR_0);
    end else if (in_byte >= CHAR_LO_A && in_byte <= CHAR_LO_F) begin
      digit = 4'(in_byte - CHAR_LO_A) + HEX_TEN;
    end else if (in_byte >= CHAR_UP_A && in_byte <= CHAR_UP_F) begin
      digit = 4'(in_byte - CHAR_UP_A) + HEX_TEN;
    end else begin
      is_hex = 1'b0;
    end
  end

  // A further digit would overflow when the top nibble is already in use.
  assign size_full = (size_accum[SIZE_BITS-1 -: 4] != 4'd0);

  // Next state and the results caused by this byte.
  always_comb begin
    phase_next        = phase;
    size_accum_next   = size_accum;
    hex_done_next     = hex_done;
    saw_cr_next       = saw_cr;
    trailer_seen_next = trailer_seen;
    entry             = '{has_data: 1'b0, data: 8'd0, has_status: 1'b0,
                          status: KIND_DATA};
    unique case (phase)
      PH_SIZE: begin
        if (saw_cr && in_byte == CHAR_LF) begin
          saw_cr_next = 1'b0;
          if (size_accum == '0) begin
            entry.has_status = 1'b1;
            entry.status     = KIND_OK;
            phase_next       = PH_IGNORE;
          end else if (final_byte) begin
            entry.has_status = 1'b1;
            entry.status     = KIND_SHORT;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          saw_cr_next = (in_byte == CHAR_CR);
          if (!hex_done && !is_hex) begin
            hex_done_next = 1'b1;
          end else if (!hex_done && size_full) begin
            entry.has_status = 1'b1;
            entry.status     = KIND_OVER;
            phase_next       = PH_IGNORE;
          end else if (!hex_done) begin
            size_accum_next = {size_accum[SIZE_BITS-5:0], digit};
          end
          if (phase_next == PH_SIZE && final_byte) begin
            entry.has_status = 1'b1;
            entry.status     = KIND_NOLINE;
          end
        end
      end
      PH_DATA: begin
        entry.has_data  = 1'b1;
        entry.data      = in_byte;
        size_accum_next = size_accum - 1'b1;
        if (size_accum == SIZE_BITS'(1)) begin
          phase_next        = PH_TRAILER;
          trailer_seen_next = 1'b0;
        end
        if (final_byte) begin
          entry.has_status = 1'b1;
          entry.status     = KIND_SHORT;
        end
      end
      PH_TRAILER: begin
        if (trailer_seen) begin
          phase_next        = PH_SIZE;
          size_accum_next   = '0;
          hex_done_next     = 1'b0;
          saw_cr_next       = 1'b0;
          trailer_seen_next = 1'b0;
          if (final_byte) begin
            entry.has_status = 1'b1;
            entry.status     = KIND_OK;
          end
        end else begin
          trailer_seen_next = 1'b1;
          if (final_byte) begin
            entry.has_status = 1'b1;
            entry.status     = KIND_SHORT;
          end
        end
      end
      PH_IGNORE: begin
      end
      default: begin
      end
    endcase
    // The last byte of a body returns everything to the start of a size line.
    if (final_byte) begin
      phase_next        = PH_SIZE;
      size_accum_next   = '0;
      hex_done_next     = 1'b0;
      saw_cr_next       = 1'b0;
      trailer_seen_next = 1'b0;
    end
  end

  assign entry_valid = accept && (entry.has_data || entry.has_status);

  // Parser state, updated on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIZE;
      size_accum   <= '0;
      hex_done     <= 1'b0;
      saw_cr       <= 1'b0;
      trailer_seen <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      size_accum   <= size_accum_next;
      hex_done     <= hex_done_next;
      saw_cr       <= saw_cr_next;
      trailer_seen <= trailer_seen_next;
    end
  end

endmodule

// ===== hw/rtl/ctd_queue.sv =====
// Short queue of classified entries between the front and back ends.
module ctd_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ctd_pkg::entry_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output ctd_pkg::entry_t rd_data,
  output logic            empty
);
  import ctd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ctd_back.sv =====
// Back end: expands queued entries into result transactions.
module ctd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  ctd_pkg::entry_t q_data,
  output logic            q_rd,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic [2:0]      kind,
  output logic            run_end
);
  import ctd_pkg::*;

  logic out_valid;
  logic data_sent;
  logic load;
  logic send_data;

  // Take the next result whenever the output register is free or emptying.
  assign load      = !q_empty && (!out_valid || pop);
  assign send_data = q_data.has_data && !data_sent;
  assign q_rd      = load && (!send_data || !q_data.has_status);
  assign empty     = !out_valid;

  // Output register and position within the current entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      data_sent <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        data_sent <= send_data && q_data.has_status;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      if (send_data) begin
        out_byte <= q_data.data;
        kind     <= KIND_DATA;
        run_end  <= !q_data.has_status;
      end else begin
        out_byte <= 8'd0;
        kind     <= q_data.status;
        run_end  <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/chunked_transfer_decoder.sv =====
// Top level of the chunked transfer decoder.
//
// Bytes of a chunked body enter on in_byte with final_byte on the last one;
// a transaction is taken when push is high and full is low. Results leave as
// out_byte, kind and run_end; the oldest one is shown while empty is low and
// is taken when pop is high. Each data byte gives a data result; size lines
// and trailers give none, and status results (body ended, unterminated size
// line, incomplete chunk, size overflow) close a body. run_end marks the last
// result of one input byte, which gives at most two.
// One byte is taken per cycle while full is low. A result passes through the
// queue and then the output register before it is shown. The output side
// delivers one result per cycle while pop is high, so a byte with both a data
// and a status result holds it until both have been shown in turn. When pop
// stays low, results collect in a queue of QUEUE_DEPTH entries behind the
// output register and full rises once that queue is full.
// Reset clears the parser to the start of a size line and discards any
// queued and waiting results. Data is streamed before a body is known to be
// good, so a consumer discards a body's data when an error status arrives.
module chunked_transfer_decoder #(
  parameter int SIZE_BITS   = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [2:0] kind,
  output logic       run_end
);
  import ctd_pkg::*;

  logic   accept;
  logic   entry_valid;
  entry_t entry;
  logic   q_empty;
  logic   q_rd;
  entry_t q_data;

  assign accept = push && !full;

  // Byte parser.
  ctd_front #(
    .SIZE_BITS(SIZE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .entry_valid(entry_valid),
    .entry      (entry)
  );

  // Decoupling queue.
  ctd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (entry_valid),
    .wr_data(entry),
    .full   (full),
    .rd_en  (q_rd),
    .rd_data(q_data),
    .empty  (q_empty)
  );

  // Result sequencer.
  ctd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .out_byte(out_byte),
    .kind    (kind),
    .run_end (run_end)
  );

endmodule

// ===== hw/rtl/ctd_checker.sv =====
// Port-level checks for the chunked transfer decoder and their binding.
module ctd_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic [2:0] kind,
  input logic       run_end
);
  import ctd_pkg::*;

  // Reset leaves no result waiting.
  assert property (@(posedge clk) rst |=> empty)
    else $error("result shown straight after reset");

  // Reset leaves room for input.
  assert property (@(posedge clk) rst |=> !full)
    else $error("full straight after reset");

  // A status result is always the last result of its input byte.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_DATA) |-> run_end)
    else $error("status result without run_end");

  // A status result carries a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_DATA) |-> (out_byte == 8'd0))
    else $error("status result with nonzero byte");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(kind)
                          && $stable(run_end)))
    else $error("waiting result changed");

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (
  .clk     (clk),
  .rst     (rst),
  .full    (full),
  .pop     (pop),
  .empty   (empty),
  .out_byte(out_byte),
  .kind    (kind),
  .run_end (run_end)
);
